@@ hdl/assert_macros.svh @@
// Assertion macros shared by the motion mask RTL.
// Define ASSERT_OFF to drop all checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is held
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/tfd_pkg.sv @@
// Shared types and constants for the three-frame-difference motion mask.
// No dependencies.
`default_nettype none

package tfd_pkg;

  // Frame geometry limits and store size
  localparam int unsigned MAX_WIDTH   = 640;
  localparam int unsigned MAX_HEIGHT  = 480;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned POS_W       = $clog2(STORE_DEPTH);

  // Configuration register widths and reset values
  localparam int unsigned CFG_W_W    = 10;
  localparam int unsigned CFG_H_W    = 9;
  localparam int unsigned CFG_T_W    = 8;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SIZE_W     = CFG_W_W + CFG_H_W;

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = CFG_H_W'(480);
  localparam logic [CFG_T_W-1:0] THRESH_RST = CFG_T_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_DIFF_THRESHOLD = 2'd2
  } cfg_idx_e;

  // Gray conversion: (B*1868 + G*9617 + R*4899 + 8192) >> 14
  localparam int unsigned GRAY_B_COEF = 1868;
  localparam int unsigned GRAY_G_COEF = 9617;
  localparam int unsigned GRAY_R_COEF = 4899;
  localparam int unsigned GRAY_SHIFT  = 14;
  localparam int unsigned GRAY_ROUND  = 8192;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned PROD_W      = 22;

  // One BGR pixel, blue in the low byte
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  localparam int unsigned PIX_W = $bits(pix_t);

  // One store entry: previous frame low, frame before that high
  typedef struct packed {
    pix_t older;
    pix_t prev;
  } store_word_t;

  localparam int unsigned WORD_W = $bits(store_word_t);

  // Sideband that rides along the pipeline with each pixel
  typedef struct packed {
    logic valid;
    logic mval;
    logic last;
  } side_t;

endpackage

`default_nettype wire

@@ hdl/three_frame_difference_motion_mask.sv @@
// Path: stage 1 (store read), the gray units' difference, product and sum registers, and the output register.
// Throughput: one pixel per cycle; the five-register pipeline stalls as a whole
//   only while the output register holds an untaken result.
// Frame store: one 48-bit RAM, one read and one write per pixel, with a bypass
//   for a write and a read of the same entry on one edge.
// Reset clears counters and valid bits and loads the configuration defaults; frame store is not cleared.
`default_nettype none

module three_frame_difference_motion_mask
  import tfd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel stream in
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,  // blue_in, green_in, red_in
  // mask stream out
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [7:0]            m_axis_tdata,  // motion_bit, zero pad
  output      logic                  m_axis_tuser,  // mask_valid
  output      logic                  m_axis_tlast   // frame_last
);

  localparam int unsigned CMP_W = (POS_W + 1 > SIZE_W) ? POS_W + 1 : SIZE_W;

  // configuration
  logic [CFG_W_W-1:0] width_q;
  logic [CFG_H_W-1:0] height_q;
  logic [CFG_T_W-1:0] thresh_q;

  // position and frame counters
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [1:0]        seen_q, seen_d;
  logic [CFG_W_W-1:0] w_eff;
  logic [CFG_H_W-1:0] h_eff;
  logic [SIZE_W-1:0] frame_size;
  logic [CMP_W-1:0]  pos_inc;
  logic              last_px;

  // pipeline control
  logic advance, accept;

  // stage 1: current pixel and stored entry
  side_t       s1_q, s1_d;
  pix_t        s1_cur_q;
  logic [POS_W-1:0] s1_pos_q;
  logic        fwd_q, fwd_d;
  store_word_t fwd_word_q;
  store_word_t rd_word, s1_word, wr_word;
  logic        wr_en;

  // stages 2 to 4 sideband, output register
  side_t           s2_q, s3_q, s4_q;
  logic [CH_W-1:0] gray_prev, gray_older;
  logic            out_valid_q, motion_q, mval_q, last_q;
  logic            motion_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && advance;
  assign s_axis_tready = advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thresh_q <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:    width_q  <= cfg_data_i[CFG_W_W-1:0];
        CFG_FRAME_HEIGHT:   height_q <= cfg_data_i[CFG_H_W-1:0];
        CFG_DIFF_THRESHOLD: thresh_q <= cfg_data_i[CFG_T_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry to 1..max, frame size and end-of-frame detect
  always_comb begin
    if (width_q == '0) begin
      w_eff = CFG_W_W'(1);
    end else if (width_q > CFG_W_W'(MAX_WIDTH)) begin
      w_eff = CFG_W_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = CFG_H_W'(1);
    end else if (height_q > CFG_H_W'(MAX_HEIGHT)) begin
      h_eff = CFG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    frame_size = SIZE_W'(w_eff) * SIZE_W'(h_eff);
    pos_inc    = CMP_W'(pos_q) + CMP_W'(1);
    last_px    = pos_inc >= CMP_W'(frame_size);
    pos_d      = last_px ? '0 : pos_inc[POS_W-1:0];
    seen_d     = (last_px && seen_q != 2'd2) ? seen_q + 2'd1 : seen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      seen_q <= seen_d;
    end
  end

  // frame store: prev and older frame in one word per pixel
  tfd_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_pos_q),
    .wdata_i (wr_word),
    .re_i    (accept),
    .raddr_i (pos_q),
    .rdata_o (rd_word)
  );

  // stage 1 word, bypassed when the entry was written on the read edge
  assign s1_word       = fwd_q ? fwd_word_q : rd_word;
  assign wr_en         = advance && s1_q.valid;
  assign wr_word.older = s1_word.prev;
  assign wr_word.prev  = s1_cur_q;
  assign fwd_d         = wr_en && (s1_pos_q == pos_q);

  assign s1_d.valid = accept;
  assign s1_d.mval  = (seen_q == 2'd2);
  assign s1_d.last  = last_px;

  // sideband valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
      s4_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_q        <= s1_d;
      s2_q        <= s1_q;
      s3_q        <= s2_q;
      s4_q        <= s3_q;
      out_valid_q <= s4_q.valid;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_cur_q   <= s_axis_tdata;
      s1_pos_q   <= pos_q;
      fwd_q      <= fwd_d;
      fwd_word_q <= wr_word;
      motion_q   <= motion_d;
      mval_q     <= s4_q.mval;
      last_q     <= s4_q.last;
    end
  end

  // difference to gray, one unit per stored frame
  tfd_diff_gray u_gray_prev (
    .clk_i  (clk_i),
    .en_i   (advance),
    .cur_i  (s1_cur_q),
    .old_i  (s1_word.prev),
    .gray_o (gray_prev)
  );

  tfd_diff_gray u_gray_older (
    .clk_i  (clk_i),
    .en_i   (advance),
    .cur_i  (s1_cur_q),
    .old_i  (s1_word.older),
    .gray_o (gray_older)
  );

  // threshold both masks and combine
  assign motion_d = s4_q.mval && (gray_prev > thresh_q) && (gray_older > thresh_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, motion_q};
  assign m_axis_tuser  = mval_q;
  assign m_axis_tlast  = last_q;

  // checks
  `include "assert_macros.svh"

  `ASSERT_RST(a_motion_needs_valid, out_valid_q && motion_q |-> mval_q,
              "motion flagged on a pixel without a valid mask")
  `ASSERT_RST(a_mask_after_two_frames, out_valid_q && mval_q |-> seen_q == 2'd2,
              "mask marked valid before two frames were stored")
  `ASSERT_RST(a_wrap_on_last, accept && last_px |=> pos_q == '0,
              "position did not return to zero after the last pixel")
  `ASSERT_RST(a_seen_saturates, seen_q != 2'd3,
              "frame counter ran past two")

endmodule

`default_nettype wire

@@ hdl/tfd_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during a write to the same address returns the old data. No dependencies.
`default_nettype none

module tfd_ram #(
  parameter  int unsigned DATA_W = 8,
  parameter  int unsigned DEPTH  = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/tfd_diff_gray.sv @@
// Three-stage datapath: per-channel absolute difference, weighted products,
// rounded gray sum. Depends on tfd_pkg.
`default_nettype none

module tfd_diff_gray
  import tfd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire pix_t            cur_i,
  input  wire pix_t            old_i,
  output      logic [CH_W-1:0] gray_o
);

  pix_t              diff_d, diff_q;
  logic [PROD_W-1:0] pb_d, pg_d, pr_d;
  logic [PROD_W-1:0] pb_q, pg_q, pr_q;
  logic [PROD_W-1:0] sum;
  logic [CH_W-1:0]   gray_d, gray_q;

  // stage 1: absolute differences
  always_comb begin
    diff_d.blue  = (cur_i.blue  > old_i.blue)  ? cur_i.blue  - old_i.blue
                                               : old_i.blue  - cur_i.blue;
    diff_d.green = (cur_i.green > old_i.green) ? cur_i.green - old_i.green
                                               : old_i.green - cur_i.green;
    diff_d.red   = (cur_i.red   > old_i.red)   ? cur_i.red   - old_i.red
                                               : old_i.red   - cur_i.red;
  end

  // stage 2: constant-coefficient products
  assign pb_d = PROD_W'(diff_q.blue)  * PROD_W'(GRAY_B_COEF);
  assign pg_d = PROD_W'(diff_q.green) * PROD_W'(GRAY_G_COEF);
  assign pr_d = PROD_W'(diff_q.red)   * PROD_W'(GRAY_R_COEF);

  // stage 3: sum, round, drop fraction (coefficients add to 1.0, so 8 bits hold it)
  assign sum    = pb_q + pg_q + pr_q + PROD_W'(GRAY_ROUND);
  assign gray_d = sum[GRAY_SHIFT +: CH_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      pb_q   <= pb_d;
      pg_q   <= pg_d;
      pr_q   <= pr_d;
      gray_q <= gray_d;
    end
  end

  assign gray_o = gray_q;

endmodule

`default_nettype wire
